// ===== rtl/bpq_pkg.sv =====
// shared constants, codes and controller/datapath interface types of the priority queue
package bpq_pkg;

    localparam int unsigned DEPTH_DEF       = 64;
    localparam int unsigned PRIO_LEVELS_DEF = 10;

    localparam int unsigned CMD_W  = 2;
    localparam int unsigned TAG_W  = 6;
    localparam int unsigned PRIO_W = 4;
    localparam int unsigned STAT_W = 2;

    // command codes, any other code only reports
    localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;

    // link ram read address select
    typedef enum logic [1:0] {
        RD_FREE,
        RD_HEAD,
        RD_NEXT
    } t_rd_sel;

    typedef struct packed {
        logic    latch_in;
        t_rd_sel rd_sel;
        logic    alloc_hwm;
        logic    alloc_free;
        logic    place_head;
        logic    place_start;
        logic    walk_step;
        logic    wr_slot_next;
        logic    link_cur;
        logic    pop;
        logic    report;
    } t_dp_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic hwm_full;
        logic head_insert;
        logic single;
        logic walk_stop;
        logic walk_last;
    } t_dp_status;

endpackage

// ===== rtl/bounded_priority_queue.sv =====
// top level of the bounded priority queue: controller plus list datapath
// states from accept to S_REPORT: status only and rejected commands go there directly,
// pop via S_POP; push via S_FREE (free-list slot only), S_PLACE, S_WALK, S_LINK as needed
// a push walks the sorted list one entry per cycle through the link ram read port
// a new item is taken in the cycle the previous result is shown; busy stays high till then
// synchronous active-low reset empties the queue at once, no clearing pass
// each result is shown for one cycle with o_valid; the receiver cannot stall
module bounded_priority_queue #(
    parameter int unsigned DEPTH       = bpq_pkg::DEPTH_DEF,
    parameter int unsigned PRIO_LEVELS = bpq_pkg::PRIO_LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item in
    input  logic                        start,
    output logic                        busy,
    input  logic [bpq_pkg::CMD_W-1:0]   i_cmd,
    input  logic [bpq_pkg::TAG_W-1:0]   i_proc_tag,
    input  logic [bpq_pkg::PRIO_W-1:0]  i_priority_req,
    // result out
    output logic                        o_valid,
    output logic [bpq_pkg::TAG_W-1:0]   o_out_tag,
    output logic [bpq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [bpq_pkg::PRIO_W-1:0]  o_head_priority,
    output logic                        o_is_empty,
    output logic                        o_is_full,
    output logic [bpq_pkg::STAT_W-1:0]  o_status
);

    // command and status between controller and datapath
    bpq_pkg::t_dp_cmd    dp_cmd;
    bpq_pkg::t_dp_status dp_st;

    // controller: decodes the item, sequences allocation, list walk, pop and report
    bpq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_st     (dp_st),
        .o_cmd    (dp_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_status (o_status)
    );

    // datapath: linked list in two rams, free list threaded through the link ram,
    // never-used slots handed out by a high-water counter
    bpq_dp #(
        .DEPTH       (DEPTH),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_proc_tag      (i_proc_tag),
        .i_priority_req  (i_priority_req),
        .i_cmd           (dp_cmd),
        .o_st            (dp_st),
        .o_out_tag       (o_out_tag),
        .o_out_priority  (o_out_priority),
        .o_head_priority (o_head_priority),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

endmodule

// ===== rtl/bpq_ram.sv =====
// generic single write port ram with registered read
module bpq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bpq_ctrl.sv =====
// sequencing state machine of the priority queue
module bpq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bpq_pkg::CMD_W-1:0]   i_cmd,
    input  bpq_pkg::t_dp_status         i_st,
    output bpq_pkg::t_dp_cmd            o_cmd,
    output logic                        o_busy,
    output logic                        o_valid,
    output logic [bpq_pkg::STAT_W-1:0]  o_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE,
        S_PLACE,
        S_WALK,
        S_LINK,
        S_POP,
        S_REPORT
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    logic                        r_valid;
    logic [bpq_pkg::STAT_W-1:0]  r_status;
    logic [bpq_pkg::STAT_W-1:0]  n_status;
    bpq_pkg::t_dp_cmd            cmd;

    always_comb begin
        n_state    = r_state;
        n_status   = r_status;
        cmd        = '0;
        cmd.rd_sel = bpq_pkg::RD_HEAD;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.latch_in = 1'b1;
                    n_status     = bpq_pkg::STAT_OK;
                    if (i_cmd == bpq_pkg::CMD_PUSH) begin
                        if (i_st.full) begin
                            n_status = bpq_pkg::STAT_PUSH_FULL;
                            n_state  = S_REPORT;
                        end else if (i_st.hwm_full) begin
                            cmd.rd_sel = bpq_pkg::RD_FREE;
                            n_state    = S_FREE;
                        end else begin
                            cmd.alloc_hwm = 1'b1;
                            n_state       = S_PLACE;
                        end
                    end else if (i_cmd == bpq_pkg::CMD_POP) begin
                        if (i_st.empty) begin
                            n_status = bpq_pkg::STAT_POP_EMPTY;
                            n_state  = S_REPORT;
                        end else begin
                            n_state = S_POP;
                        end
                    end else begin
                        n_state = S_REPORT;
                    end
                end
            end
            S_FREE: begin
                cmd.alloc_free = 1'b1;
                n_state        = S_PLACE;
            end
            S_PLACE: begin
                if (i_st.head_insert) begin
                    cmd.place_head = 1'b1;
                    n_state        = S_REPORT;
                end else begin
                    cmd.place_start = 1'b1;
                    n_state         = i_st.single ? S_LINK : S_WALK;
                end
            end
            S_WALK: begin
                cmd.rd_sel = bpq_pkg::RD_NEXT;
                if (i_st.walk_stop) begin
                    cmd.wr_slot_next = 1'b1;
                    n_state          = S_LINK;
                end else begin
                    cmd.walk_step = 1'b1;
                    if (i_st.walk_last) begin
                        n_state = S_LINK;
                    end
                end
            end
            S_LINK: begin
                cmd.link_cur = 1'b1;
                n_state      = S_REPORT;
            end
            S_POP: begin
                cmd.pop = 1'b1;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                cmd.report = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= cmd.report;
        end
    end

    assign o_cmd    = cmd;
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

// ===== rtl/bpq_dp.sv =====
// list datapath: slot allocation, link walk, head and count registers, result registers
module bpq_dp #(
    parameter int unsigned DEPTH       = bpq_pkg::DEPTH_DEF,
    parameter int unsigned PRIO_LEVELS = bpq_pkg::PRIO_LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [bpq_pkg::TAG_W-1:0]   i_proc_tag,
    input  logic [bpq_pkg::PRIO_W-1:0]  i_priority_req,
    input  bpq_pkg::t_dp_cmd            i_cmd,
    output bpq_pkg::t_dp_status         o_st,
    output logic [bpq_pkg::TAG_W-1:0]   o_out_tag,
    output logic [bpq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [bpq_pkg::PRIO_W-1:0]  o_head_priority,
    output logic                        o_is_empty,
    output logic                        o_is_full
);

    localparam int unsigned IW   = $clog2(DEPTH);
    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned PW   = bpq_pkg::PRIO_W;
    localparam int unsigned TW   = bpq_pkg::TAG_W;
    localparam int unsigned LW   = IW + PW;
    localparam int unsigned PCAP = (PRIO_LEVELS > (2 ** PW) - 1) ? (2 ** PW) - 1 : PRIO_LEVELS;
    localparam logic [PW-1:0] PMAX    = PW'(PCAP);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [IW-1:0] r_head;
    logic [PW-1:0] r_head_prio;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_hwm;
    logic [IW-1:0] r_free;
    logic [IW-1:0] r_slot;
    logic [IW-1:0] r_cur;
    logic [CW-1:0] r_rem;
    logic [TW-1:0] r_tag;
    logic [PW-1:0] r_prio;
    logic [TW-1:0] r_pop_tag;
    logic [PW-1:0] r_pop_prio;
    logic [TW-1:0] r_out_tag;
    logic [PW-1:0] r_out_prio;
    logic [PW-1:0] r_out_head_prio;
    logic          r_out_empty;
    logic          r_out_full;

    logic [PW-1:0] prio_in;
    logic          empty;

    // each link word holds the next slot and that slot's priority
    logic          link_we;
    logic [IW-1:0] link_waddr;
    logic [LW-1:0] link_wdata;
    logic [IW-1:0] link_raddr;
    logic [LW-1:0] link_rdata;
    logic [IW-1:0] nx;
    logic [PW-1:0] nxp;
    logic [TW-1:0] tag_rdata;

    assign nx    = link_rdata[LW-1:PW];
    assign nxp   = link_rdata[PW-1:0];
    assign empty = (r_count == '0);

    always_comb begin
        if (i_priority_req == '0) begin
            prio_in = PW'(1);
        end else if (i_priority_req > PMAX) begin
            prio_in = PMAX;
        end else begin
            prio_in = i_priority_req;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            bpq_pkg::RD_FREE: link_raddr = r_free;
            bpq_pkg::RD_HEAD: link_raddr = r_head;
            bpq_pkg::RD_NEXT: link_raddr = nx;
            default:          link_raddr = r_head;
        endcase
    end

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_slot;
        link_wdata = {r_head, r_head_prio};
        priority if (i_cmd.place_head) begin
            link_we = 1'b1;
        end else if (i_cmd.wr_slot_next) begin
            link_we    = 1'b1;
            link_wdata = link_rdata;
        end else if (i_cmd.link_cur) begin
            link_we    = 1'b1;
            link_waddr = r_cur;
            link_wdata = {r_slot, r_prio};
        end else if (i_cmd.pop) begin
            // freed slot goes on top of the free list
            link_we    = 1'b1;
            link_waddr = r_head;
            link_wdata = {r_free, {PW{1'b0}}};
        end
    end

    bpq_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    bpq_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.place_head | i_cmd.place_start),
        .i_waddr (r_slot),
        .i_wdata (r_tag),
        .i_raddr (r_head),
        .o_rdata (tag_rdata)
    );

    always_comb begin
        o_st.empty       = empty;
        o_st.full        = (r_count == DEPTH_C);
        o_st.hwm_full    = (r_hwm == DEPTH_C);
        o_st.head_insert = empty || (r_prio < r_head_prio);
        o_st.single      = (r_count == CW'(1));
        o_st.walk_stop   = (nxp > r_prio);
        o_st.walk_last   = (r_rem == CW'(1));
    end

    // list control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_hwm   <= '0;
        end else begin
            if (i_cmd.alloc_hwm) begin
                r_hwm <= r_hwm + CW'(1);
            end
            if (i_cmd.place_head) begin
                r_head  <= r_slot;
                r_count <= r_count + CW'(1);
            end else if (i_cmd.link_cur) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= (r_count == CW'(1)) ? '0 : nx;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_tag      <= i_proc_tag;
            r_prio     <= prio_in;
            r_pop_tag  <= '0;
            r_pop_prio <= '0;
        end
        if (i_cmd.alloc_hwm) begin
            r_slot <= r_hwm[IW-1:0];
        end
        if (i_cmd.alloc_free) begin
            r_slot <= r_free;
            r_free <= nx;
        end
        if (i_cmd.place_head) begin
            r_head_prio <= r_prio;
        end
        if (i_cmd.place_start) begin
            r_cur <= r_head;
            r_rem <= r_count - CW'(1);
        end
        if (i_cmd.walk_step) begin
            r_cur <= nx;
            r_rem <= r_rem - CW'(1);
        end
        if (i_cmd.pop) begin
            r_pop_tag   <= tag_rdata;
            r_pop_prio  <= r_head_prio;
            r_free      <= r_head;
            r_head_prio <= nxp;
        end
        if (i_cmd.report) begin
            r_out_tag       <= r_pop_tag;
            r_out_prio      <= r_pop_prio;
            r_out_head_prio <= empty ? '0 : r_head_prio;
            r_out_empty     <= empty;
            r_out_full      <= (r_count == DEPTH_C);
        end
    end

    assign o_out_tag       = r_out_tag;
    assign o_out_priority  = r_out_prio;
    assign o_head_priority = r_out_head_prio;
    assign o_is_empty      = r_out_empty;
    assign o_is_full       = r_out_full;

endmodule

// ===== rtl/bpq_checker.sv =====
// port-level checks of the priority queue and their bind to the top level
module bpq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic [bpq_pkg::TAG_W-1:0]   o_out_tag,
    input logic [bpq_pkg::PRIO_W-1:0]  o_out_priority,
    input logic                        o_is_empty,
    input logic                        o_is_full,
    input logic [bpq_pkg::STAT_W-1:0]  o_status
);

    // an accepted item raises busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result is shown while idle and never twice in a row
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_empty_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_empty && o_is_full))
        else $error("queue reported empty and full together");

    // a rejected command removes nothing
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bpq_pkg::STAT_OK)) |->
        ((o_out_tag == '0) && (o_out_priority == '0)))
        else $error("rejected command returned an entry");

endmodule

bind bounded_priority_queue bpq_checker u_bpq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_out_tag      (o_out_tag),
    .o_out_priority (o_out_priority),
    .o_is_empty     (o_is_empty),
    .o_is_full      (o_is_full),
    .o_status       (o_status)
);
